// ----- src/voxel_line_clip_and_scan_unit_defines.svh -----
// Assertion macros shared by the voxel line clip and scan unit.
`ifndef VOXEL_LINE_CLIP_AND_SCAN_UNIT_DEFINES_SVH
`define VOXEL_LINE_CLIP_AND_SCAN_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLCS_CHECK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VLCS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/vlcs_pkg.sv -----
// Shared types and constants of the voxel line clip and scan unit.
package vlcs_pkg;

  localparam int MAX_SIZE_LOG2_DEF = 5;
  localparam int CELL_BITS_DEF     = 8;
  localparam int FRAC_BITS_DEF     = 8;

  // Coordinate width after saturation, difference width and product width.
  localparam int CW       = 26;
  localparam int DW       = CW + 1;
  localparam int PW       = 2 * DW;
  localparam int MD_CNT_W = $clog2(PW);

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_MD_CLIP,
    DP_WR_CLIP,
    DP_SET_LIM,
    DP_ORDER,
    DP_MD_SCAN,
    DP_WR_SCAN,
    DP_WRITE_CELL,
    DP_READ_CELL,
    DP_OUT_HIT,
    DP_OUT_MISS
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       zero_fill;
    logic       side;
    logic       upper;
    logic [1:0] axis;
    logic       minor;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic dm_nz;
    logic md_busy;
    logic triv_miss;
    logic box_miss;
    logic k_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_TRIV,
    S_TEST,
    S_MD_GO,
    S_MD_WAIT,
    S_LIM,
    S_FINAL,
    S_ORDER,
    S_SC_GO,
    S_SC_WAIT,
    S_MEM,
    S_OUT,
    S_MISS
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

endpackage

// ----- src/voxel_line_clip_and_scan_unit.sv -----
// Top level of the voxel line clip and scan unit.
//
// channel | signals                        | transaction moves
// in      | in_valid / in_ready            | one draw, check or clear item
// out     | out_valid / out_ready          | one check result
// cfg     | cfg_valid / cfg_ready          | one size register write
//
// Reset and each clear item sweep the whole store, one cell a cycle.
// A line not trivially rejected runs twelve clip tests; a firing test on an axis with
// nonzero extent adds two multiply-divides on the shared serial unit.
// Each scanned cell takes two more multiply-divides plus a memory access.
// A stalled result register holds the scan until out_ready frees it.
`include "voxel_line_clip_and_scan_unit_defines.svh"
module voxel_line_clip_and_scan_unit
  import vlcs_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
  parameter int CELL_BITS     = CELL_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [23:0] start_x,
  input  logic signed [23:0] start_y,
  input  logic signed [23:0] start_z,
  input  logic signed [23:0] end_x,
  input  logic signed [23:0] end_y,
  input  logic signed [23:0] end_z,
  input  logic [7:0]         cell_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         read_value,
  output logic [4:0]         step_index,
  output logic               hit,
  output logic               last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Size registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  vlcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  vlcs_datapath #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .CELL_BITS     (CELL_BITS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_x    (start_x),
    .start_y    (start_y),
    .start_z    (start_z),
    .end_x      (end_x),
    .end_y      (end_y),
    .end_z      (end_z),
    .cell_value (cell_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .read_value (read_value),
    .step_index (step_index),
    .hit        (hit),
    .last       (last)
  );

  `VLCS_CHECK_SAME(a_out_no_overwrite, clk, rst,
                   (cmd.op == DP_OUT_HIT) || (cmd.op == DP_OUT_MISS),
                   !out_valid || out_ready, "result register overwritten")
  `VLCS_CHECK_SAME(a_md_start_idle, clk, rst,
                   (cmd.op == DP_MD_CLIP) || (cmd.op == DP_MD_SCAN),
                   !stat.md_busy, "multiply-divide started while busy")
  `VLCS_CHECK_NEXT(a_busy_after_item, clk, rst,
                   in_valid && in_ready && (kind != KIND_NONE),
                   !in_ready, "new item taken while one is in work")

endmodule

// ----- src/vlcs_muldiv.sv -----
// Bit-serial signed multiply then divide unit, quotient truncated toward zero.
module vlcs_muldiv
  import vlcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  input  logic signed [DW-1:0] c,
  output logic                busy,
  output logic signed [PW:0]  q
);

  md_state_t             state, state_next;
  logic [MD_CNT_W-1:0]   cnt;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         mcand;
  logic [DW-1:0]         mplier;
  logic [DW-1:0]         dvsr;
  logic [DW-1:0]         rem;
  logic                  neg;
  logic [DW:0]           rem_sh;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  assign rem_sh = {rem, prod[PW-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (start) state_next = MD_MUL;
      MD_MUL:  if (cnt == MD_CNT_W'(DW - 1)) state_next = MD_DIV;
      MD_DIV:  if (cnt == MD_CNT_W'(PW - 1)) state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else if (state != MD_IDLE) cnt <= cnt + MD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          mcand  <= PW'(mag(a));
          mplier <= mag(b);
          dvsr   <= mag(c);
          prod   <= '0;
          neg    <= a[DW-1] ^ b[DW-1] ^ c[DW-1];
        end
      end
      MD_MUL: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        rem    <= '0;
      end
      MD_DIV: begin
        // Restoring division: the quotient bits shift into prod from the right.
        if (rem_sh >= {1'b0, dvsr}) begin
          rem  <= DW'(rem_sh - {1'b0, dvsr});
          prod <= {prod[PW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[DW-1:0];
          prod <= {prod[PW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != MD_IDLE);
  assign q    = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

endmodule

// ----- src/vlcs_datapath.sv -----
// Datapath: coordinates, clipping arithmetic, cell addressing, cell store and result register.
module vlcs_datapath
  import vlcs_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
  parameter int CELL_BITS     = CELL_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic signed [23:0] start_x,
  input  logic signed [23:0] start_y,
  input  logic signed [23:0] start_z,
  input  logic signed [23:0] end_x,
  input  logic signed [23:0] end_y,
  input  logic signed [23:0] end_z,
  input  logic [7:0]         cell_value,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         read_value,
  output logic [4:0]         step_index,
  output logic               hit,
  output logic               last
);

  localparam int AW    = 3 * MAX_SIZE_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = MAX_SIZE_LOG2 + 1;
  localparam int MW    = MAX_SIZE_LOG2;
  localparam int SW    = PW + 2;
  localparam logic [2:0] LOG2_RESET = 3'd5;
  localparam logic [1:0] CFG_X = 2'd0;
  localparam logic [1:0] CFG_Y = 2'd1;
  localparam logic [1:0] CFG_Z = 2'd2;

  logic [2:0]             size_log2 [3];
  logic [2:0]             n [3];
  logic signed [CW-1:0]   hi [3];
  logic signed [CW-1:0]   p [2][3];
  logic signed [DW-1:0]   d_all [3];
  logic [DW-1:0]          d_abs [3];
  logic [CELL_BITS-1:0]   val;
  logic [1:0]             ia, ia_w;
  logic [KW-1:0]          k, len;
  logic [MW-1:0]          cm [2];
  logic [AW-1:0]          clr_addr;
  logic [CELL_BITS-1:0]   mem [DEPTH];
  logic [CELL_BITS-1:0]   rdata;

  logic                   scan;
  logic [1:0]             j_ax, j;
  logic signed [CW-1:0]   ps_ax, lim, base;
  logic signed [DW-1:0]   num, md_a, md_b, md_c;
  logic signed [PW:0]     md_q;
  logic                   md_start;
  logic signed [SW-1:0]   sum;
  logic signed [CW-1:0]   sat;
  logic [MW-1:0]          a0, a1;
  logic [MW-1:0]          cl [3];
  logic [MW-1:0]          cmask [3];
  logic [AW-1:0]          addr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [CELL_BITS-1:0]   wdata;

  function automatic logic [2:0] eff_log2(input logic [2:0] r);
    return (r > 3'(MAX_SIZE_LOG2)) ? 3'(MAX_SIZE_LOG2) : r;
  endfunction

  // The two minor axes of a major axis, in rising order from it.
  function automatic logic [1:0] next_axis(input logic [1:0] a, input logic m);
    logic [1:0] r;
    case (a)
      2'd0:    r = m ? 2'd2 : 2'd1;
      2'd1:    r = m ? 2'd0 : 2'd2;
      default: r = m ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      n[x]     = eff_log2(size_log2[x]);
      hi[x]    = ((CW'(1) << n[x]) - CW'(1)) << FRAC_BITS;
      d_all[x] = DW'(p[1][x]) - DW'(p[0][x]);
      d_abs[x] = d_all[x][DW-1] ? DW'(-d_all[x]) : DW'(d_all[x]);
    end
  end

  assign scan  = (cmd.op == DP_MD_SCAN) || (cmd.op == DP_WR_SCAN);
  assign j_ax  = scan ? ia : cmd.axis;
  assign j     = next_axis(j_ax, cmd.minor);
  assign ps_ax = p[cmd.side][cmd.axis];
  assign lim   = cmd.upper ? hi[cmd.axis] : '0;
  assign num   = DW'(lim) - DW'(ps_ax);

  assign md_a     = scan ? d_all[j] : num;
  assign md_b     = scan ? DW'(k) : d_all[j];
  assign md_c     = scan ? DW'(len) : d_all[cmd.axis];
  assign md_start = (cmd.op == DP_MD_CLIP) || (cmd.op == DP_MD_SCAN);

  vlcs_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .busy  (stat.md_busy),
    .q     (md_q)
  );

  assign base = scan ? p[0][j] : p[cmd.side][j];
  assign sum  = SW'(base) + SW'(md_q);

  // Saturate to the coordinate range: the upper bits must all copy the sign.
  always_comb begin
    if ((&sum[SW-1:CW-1]) || !(|sum[SW-1:CW-1])) sat = sum[CW-1:0];
    else if (sum[SW-1]) sat = {1'b1, {(CW-1){1'b0}}};
    else sat = {1'b0, {(CW-1){1'b1}}};
  end

  // Major axis by largest extent; the ends swap later, in DP_ORDER.
  always_comb begin
    if (d_abs[0] > d_abs[1]) ia_w = (d_abs[0] > d_abs[2]) ? 2'd0 : 2'd2;
    else ia_w = (d_abs[1] > d_abs[2]) ? 2'd1 : 2'd2;
  end

  assign a0  = p[0][ia][FRAC_BITS+MW-1:FRAC_BITS];
  assign a1  = p[1][ia][FRAC_BITS+MW-1:FRAC_BITS];
  assign len = KW'(a1) - KW'(a0) + KW'(1);

  always_comb begin
    cl[0] = '0;
    cl[1] = '0;
    cl[2] = '0;
    cl[ia] = a0 + k[MW-1:0];
    cl[next_axis(ia, 1'b0)] = cm[0];
    cl[next_axis(ia, 1'b1)] = cm[1];
    for (int x = 0; x < 3; x++) begin
      cmask[x] = cl[x] & ((MW'(1) << n[x]) - MW'(1));
    end
    addr = AW'(cmask[0]) | (AW'(cmask[1]) << n[0])
         | (AW'(cmask[2]) << ({1'b0, n[0]} + {1'b0, n[1]}));
  end

  always_comb begin
    stat.triv_miss = 1'b0;
    stat.box_miss  = 1'b0;
    for (int x = 0; x < 3; x++) begin
      if ((p[0][x] < 0 && p[1][x] < 0) || (p[0][x] > hi[x] && p[1][x] > hi[x]))
        stat.triv_miss = 1'b1;
      if (p[0][x] < 0 || p[0][x] > hi[x] || p[1][x] < 0 || p[1][x] > hi[x])
        stat.box_miss = 1'b1;
    end
  end

  assign stat.fire     = cmd.upper ? (ps_ax > hi[cmd.axis]) : ps_ax[CW-1];
  assign stat.dm_nz    = (d_all[cmd.axis] != '0);
  assign stat.k_last   = ((k + KW'(1)) == len);
  assign stat.clr_last = &clr_addr;
  assign stat.out_free = !out_valid || out_ready;

  assign we    = (cmd.op == DP_CLR_STEP) || (cmd.op == DP_WRITE_CELL);
  assign waddr = (cmd.op == DP_CLR_STEP) ? clr_addr : addr;
  assign wdata = cmd.zero_fill ? '0 : val;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.op == DP_READ_CELL) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2[0] <= LOG2_RESET;
      size_log2[1] <= LOG2_RESET;
      size_log2[2] <= LOG2_RESET;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_X:   size_log2[0] <= cfg_data;
          CFG_Y:   size_log2[1] <= cfg_data;
          CFG_Z:   size_log2[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == DP_CLR_STEP) clr_addr <= clr_addr + AW'(1);
      if ((cmd.op == DP_OUT_HIT) || (cmd.op == DP_OUT_MISS)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        p[0][0] <= CW'(start_x);
        p[0][1] <= CW'(start_y);
        p[0][2] <= CW'(start_z);
        p[1][0] <= CW'(end_x);
        p[1][1] <= CW'(end_y);
        p[1][2] <= CW'(end_z);
        val     <= CELL_BITS'(cell_value);
      end
      DP_WR_CLIP: p[cmd.side][j] <= sat;
      DP_SET_LIM: p[cmd.side][cmd.axis] <= lim;
      DP_ORDER: begin
        ia <= ia_w;
        k  <= '0;
        if (p[0][ia_w] > p[1][ia_w]) begin
          for (int x = 0; x < 3; x++) begin
            p[0][x] <= p[1][x];
            p[1][x] <= p[0][x];
          end
        end
      end
      DP_WR_SCAN: cm[cmd.minor] <= sat[FRAC_BITS+MW-1:FRAC_BITS];
      DP_WRITE_CELL: k <= k + KW'(1);
      DP_OUT_HIT: begin
        k          <= k + KW'(1);
        read_value <= 8'(rdata);
        step_index <= 5'(k);
        hit        <= 1'b1;
        last       <= stat.k_last;
      end
      DP_OUT_MISS: begin
        read_value <= '0;
        step_index <= '0;
        hit        <= 1'b0;
        last       <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/vlcs_ctrl.sv -----
// Controller: sequences clear sweeps, clipping steps and the cell scan.
module vlcs_ctrl
  import vlcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        side, upper, minor, is_check;
  logic [1:0]  axis;
  logic        clip_done;

  // The last clip test is the upper bound of z on the end point.
  assign clip_done = side && upper && (axis == 2'd2);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_CLEAR) state_next = S_CLEAR;
          else if (kind == KIND_DRAW || kind == KIND_CHECK) state_next = S_TRIV;
        end
      end
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_TRIV: begin
        if (stat.triv_miss) state_next = is_check ? S_MISS : S_IDLE;
        else state_next = S_TEST;
      end
      S_TEST: begin
        if (stat.fire) state_next = stat.dm_nz ? S_MD_GO : S_LIM;
        else if (clip_done) state_next = S_FINAL;
      end
      S_MD_GO: state_next = S_MD_WAIT;
      S_MD_WAIT: if (!stat.md_busy) state_next = minor ? S_LIM : S_MD_GO;
      S_LIM:   state_next = clip_done ? S_FINAL : S_TEST;
      S_FINAL: begin
        if (stat.box_miss) state_next = is_check ? S_MISS : S_IDLE;
        else state_next = S_ORDER;
      end
      S_ORDER: state_next = S_SC_GO;
      S_SC_GO: state_next = S_SC_WAIT;
      S_SC_WAIT: if (!stat.md_busy) state_next = minor ? S_MEM : S_SC_GO;
      S_MEM: begin
        if (is_check) state_next = S_OUT;
        else state_next = stat.k_last ? S_IDLE : S_SC_GO;
      end
      S_OUT:  if (stat.out_free) state_next = stat.k_last ? S_IDLE : S_SC_GO;
      S_MISS: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = DP_NOP;
    cmd.zero_fill = (state == S_INIT);
    cmd.side      = side;
    cmd.upper     = upper;
    cmd.axis      = axis;
    cmd.minor     = minor;
    unique case (state)
      S_INIT:    cmd.op = DP_CLR_STEP;
      S_IDLE:    if (in_valid) cmd.op = DP_LOAD;
      S_CLEAR:   cmd.op = DP_CLR_STEP;
      S_MD_GO:   cmd.op = DP_MD_CLIP;
      S_MD_WAIT: if (!stat.md_busy) cmd.op = DP_WR_CLIP;
      S_LIM:     cmd.op = DP_SET_LIM;
      S_ORDER:   cmd.op = DP_ORDER;
      S_SC_GO:   cmd.op = DP_MD_SCAN;
      S_SC_WAIT: if (!stat.md_busy) cmd.op = DP_WR_SCAN;
      S_MEM:     cmd.op = is_check ? DP_READ_CELL : DP_WRITE_CELL;
      S_OUT:     if (stat.out_free) cmd.op = DP_OUT_HIT;
      S_MISS:    if (stat.out_free) cmd.op = DP_OUT_MISS;
      default:   cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      side     <= 1'b0;
      upper    <= 1'b0;
      axis     <= 2'd0;
      minor    <= 1'b0;
      is_check <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        side     <= 1'b0;
        upper    <= 1'b0;
        axis     <= 2'd0;
        minor    <= 1'b0;
        is_check <= (kind == KIND_CHECK);
      end
      // Tests run lower bounds x, y, z then upper bounds, start point first.
      if ((state == S_TEST && !stat.fire) || state == S_LIM) begin
        if (axis == 2'd2) begin
          axis  <= 2'd0;
          upper <= !upper;
          if (upper) side <= !side;
        end else begin
          axis <= axis + 2'd1;
        end
      end
      if (state == S_TEST || state == S_ORDER) minor <= 1'b0;
      if ((state == S_MD_WAIT || state == S_SC_WAIT) && !stat.md_busy) minor <= !minor;
    end
  end

endmodule

// ----- sim/tb_voxel_line_clip_and_scan_unit.sv -----
// Self-checking testbench of the voxel line clip and scan unit.
`timescale 1ns / 1ps
module tb_voxel_line_clip_and_scan_unit;
  import vlcs_pkg::*;

  localparam logic [1:0] REG_X_SIZE = 2'd0;
  localparam logic [1:0] REG_Y_SIZE = 2'd1;
  localparam logic [1:0] REG_Z_SIZE = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int GRID_LOG2   = 5;
  localparam int GRID_DEPTH  = 1 << (3 * GRID_LOG2);
  localparam int FRAC        = 8;
  localparam int DRAIN_CYC   = 40000;
  localparam int WDOG_LIMIT  = 200000;
  localparam int HOLD_CYC    = 20000;
  localparam longint SAT_MAX = (64'sd1 <<< 25) - 1;
  localparam longint SAT_MIN = -(64'sd1 <<< 25);

  typedef struct packed {
    logic [7:0] read_value;
    logic [4:0] step_index;
    logic       hit;
    logic       last;
  } scan_res_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] sx, sy, sz, ex, ey, ez;
    logic [7:0]         value;
    logic               miss_typed;
  } line_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;
  logic in_valid = 0;
  logic [1:0] kind = '0;
  logic signed [23:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [23:0] end_x = '0, end_y = '0, end_z = '0;
  logic [7:0] cell_value = '0;
  logic out_ready = 0;
  logic cfg_ready, in_ready, out_valid, hit, last;
  logic [7:0] read_value;
  logic [4:0] step_index;

  voxel_line_clip_and_scan_unit dut (.*);

  always #5 clk = ~clk;

  // Predictor state: grid contents, size registers and the working segment.
  logic [7:0] grid [GRID_DEPTH];
  logic [2:0] size_reg [3];
  longint seg [2][3];
  scan_res_t expected_scan[$];
  line_row_t dir_rows[$];
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clears_sent = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int hold_left = 0;

  function automatic longint sat26(longint v);
    return v > SAT_MAX ? SAT_MAX : (v < SAT_MIN ? SAT_MIN : v);
  endfunction

  function automatic void clip_to_plane(int side, int ax, longint lim);
    longint d [3];
    longint num;
    for (int j = 0; j < 3; j++) d[j] = seg[1][j] - seg[0][j];
    if (d[ax] != 0) begin
      num = lim - seg[side][ax];
      for (int j = 0; j < 3; j++)
        if (j != ax) seg[side][j] = sat26(seg[side][j] + (num * d[j]) / d[ax]);
    end
    seg[side][ax] = lim;
  endfunction

  function automatic void predict_line(line_row_t r);
    int n [3], sh [3];
    longint hi [3], diff [3], a0, a1, len, b, c, t;
    int ia, ib, ic;
    int ca, cb, cc, addr;
    bit miss;
    miss = 0;
    if (r.kind == KIND_CLEAR) begin
      for (int k = 0; k < GRID_DEPTH; k++) grid[k] = r.value;
      return;
    end
    if (r.kind == KIND_NONE) return;
    for (int j = 0; j < 3; j++) n[j] = size_reg[j] > GRID_LOG2 ? GRID_LOG2 : size_reg[j];
    sh[0] = 0; sh[1] = n[0]; sh[2] = n[0] + n[1];
    seg[0][0] = r.sx; seg[0][1] = r.sy; seg[0][2] = r.sz;
    seg[1][0] = r.ex; seg[1][1] = r.ey; seg[1][2] = r.ez;
    for (int j = 0; j < 3; j++) begin
      hi[j] = ((64'sd1 <<< n[j]) - 1) <<< FRAC;
      if ((seg[0][j] < 0 && seg[1][j] < 0) || (seg[0][j] > hi[j] && seg[1][j] > hi[j]))
        miss = 1;
    end
    if (!miss) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) if (seg[i][j] < 0) clip_to_plane(i, j, 0);
        for (int j = 0; j < 3; j++) if (seg[i][j] > hi[j]) clip_to_plane(i, j, hi[j]);
      end
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 3; j++)
          if (seg[i][j] < 0 || seg[i][j] > hi[j]) miss = 1;
    end
    if (miss) begin
      if (r.kind == KIND_CHECK) expected_scan.push_back('{8'd0, 5'd0, 1'b0, 1'b1});
      return;
    end
    for (int j = 0; j < 3; j++) diff[j] = seg[1][j] - seg[0][j];
    for (int j = 0; j < 3; j++) if (diff[j] < 0) hi[j] = -diff[j]; else hi[j] = diff[j];
    // hi now holds the absolute extents.
    if (hi[0] > hi[1]) ia = hi[0] > hi[2] ? 0 : 2;
    else ia = hi[1] > hi[2] ? 1 : 2;
    ib = (ia + 1) % 3;
    ic = (ia + 2) % 3;
    if (seg[0][ia] > seg[1][ia]) begin
      for (int j = 0; j < 3; j++) begin
        t = seg[0][j]; seg[0][j] = seg[1][j]; seg[1][j] = t;
        diff[j] = -diff[j];
      end
    end
    a0 = seg[0][ia] >>> FRAC;
    a1 = seg[1][ia] >>> FRAC;
    len = a1 - a0 + 1;
    for (longint k = 0; k < len; k++) begin
      b = seg[0][ib] + (diff[ib] * k) / len;
      c = seg[0][ic] + (diff[ic] * k) / len;
      ca = int'(a0 + k) & ((1 << n[ia]) - 1);
      cb = int'(b >>> FRAC) & ((1 << n[ib]) - 1);
      cc = int'(c >>> FRAC) & ((1 << n[ic]) - 1);
      addr = ((ca << sh[ia]) | (cb << sh[ib]) | (cc << sh[ic])) & (GRID_DEPTH - 1);
      if (r.kind == KIND_DRAW) grid[addr] = r.value;
      else expected_scan.push_back('{grid[addr], 5'(k), 1'b1, 1'(k == len - 1)});
    end
  endfunction

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    scan_res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_scan.size() == 0) begin
        $error("result transaction with nothing expected");
        err_count++;
      end else begin
        want = expected_scan.pop_front();
        if (read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, read_value);
          err_count++;
        end
        if (step_index !== want.step_index) begin
          $error("step_index: expected %0d, got %0d", want.step_index, step_index);
          err_count++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          err_count++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_size(logic [1:0] idx, logic [2:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx != REG_UNUSED) size_reg[idx] = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (expected_scan.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic send_line(line_row_t r);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    kind = r.kind;
    start_x = r.sx; start_y = r.sy; start_z = r.sz;
    end_x = r.ex; end_y = r.ey; end_z = r.ez;
    cell_value = r.value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (r.kind == KIND_CLEAR) clears_sent++;
    if (r.miss_typed) begin
      predict_line(r);
      void'(expected_scan.pop_back());
      expected_scan.push_back('{8'd0, 5'd0, 1'b0, 1'b1});
    end else begin
      predict_line(r);
    end
  endtask

  function automatic logic signed [23:0] pick_coord(int ax);
    int n;
    int span;
    n = size_reg[ax] > GRID_LOG2 ? GRID_LOG2 : size_reg[ax];
    span = ((1 << n) - 1) << FRAC;
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, span + 1024)) - 512);
  endfunction

  function automatic line_row_t random_line();
    line_row_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.kind = sel < 45 ? KIND_CHECK : (sel < 94 ? KIND_DRAW : (sel < 98 ? KIND_NONE : KIND_CLEAR));
    r.sx = pick_coord(0); r.sy = pick_coord(1); r.sz = pick_coord(2);
    r.ex = pick_coord(0); r.ey = pick_coord(1); r.ez = pick_coord(2);
    r.value = 8'($urandom);
    r.miss_typed = 0;
    return r;
  endfunction

  task automatic add_row(kind_t k, int sx, int sy, int sz, int ex, int ey, int ez,
                         int val, bit typed);
    dir_rows.push_back('{k, 24'(sx), 24'(sy), 24'(sz), 24'(ex), 24'(ey), 24'(ez),
                         8'(val), typed});
  endtask

  task automatic random_phase(int count, int phase);
    for (int i = 0; i < count; i++) begin
      if (phase == 2 && i == 5) hold_req = 1;
      if (phase == 3 && i == 10) begin
        @(negedge clk);
        in_valid = 0;
        wait (expected_scan.size() == 0);
      end
      send_line(random_line());
    end
  endtask

  initial begin
    int top;
    top = 31 << FRAC;
    for (int k = 0; k < GRID_DEPTH; k++) grid[k] = '0;
    for (int j = 0; j < 3; j++) size_reg[j] = 3'd5;
    repeat (8) @(posedge clk);
    rst <= 0;

    add_row(KIND_CHECK, -300, 10, 10, -5, 4000, 100, 0, 1);
    add_row(KIND_CHECK, 100, top + 1, 0, 200, 8388607, 5, 0, 1);
    add_row(KIND_CHECK, 0, 0, 0, top, 0, 0, 0, 0);
    add_row(KIND_DRAW, 0, 0, 0, top, 0, 0, 255, 0);
    add_row(KIND_CHECK, top, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_DRAW, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0, 0);
    add_row(KIND_CHECK, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0, 0);
    add_row(KIND_NONE, 0, 0, 0, top, top, top, 77, 0);
    add_row(KIND_DRAW, 300, -900, 1000, 2000, top + 900, 1500, 42, 0);
    add_row(KIND_CHECK, 300, -900, 1000, 2000, top + 900, 1500, 0, 0);
    add_row(KIND_DRAW, 500, 600, top, 700, 900, 0, 9, 0);
    add_row(KIND_CHECK, 500, 600, -40, 700, 900, top + 40, 0, 0);
    add_row(KIND_CHECK, 1234, 2345, 3456, 1234, 2345, 3456, 0, 0);
    add_row(KIND_DRAW, -2560, 256, 0, 256, -2560, 0, 5, 0);
    add_row(KIND_CHECK, -2560, 256, 0, 256, -2560, 0, 0, 1);
    add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 165, 0);
    add_row(KIND_CHECK, 0, top, 0, top, 0, top, 0, 0);
    add_row(KIND_DRAW, 0, top, 0, top, 0, top, 0, 0);
    add_row(KIND_CHECK, 0, top, 0, top, 0, top, 0, 0);
    foreach (dir_rows[i]) send_line(dir_rows[i]);
    random_phase(30, 0);

    drain();
    write_size(REG_X_SIZE, 3'd0);
    write_size(REG_Y_SIZE, 3'd0);
    write_size(REG_Z_SIZE, 3'd0);
    random_phase(25, 1);

    drain();
    write_size(REG_X_SIZE, 3'd5);
    write_size(REG_Z_SIZE, 3'd3);
    random_phase(35, 2);

    drain();
    write_size(REG_X_SIZE, 3'd2);
    write_size(REG_Y_SIZE, 3'd3);
    write_size(REG_Z_SIZE, 3'd1);
    quiet = 1;
    random_phase(35, 3);
    quiet = 0;

    drain();
    write_size(REG_X_SIZE, 3'd7);
    write_size(REG_Y_SIZE, 3'd6);
    write_size(REG_Z_SIZE, 3'd4);
    write_size(REG_UNUSED, 3'd2);
    random_phase(35, 4);

    drain();
    write_size(REG_X_SIZE, 3'd1);
    write_size(REG_Y_SIZE, 3'd5);
    write_size(REG_Z_SIZE, 3'd2);
    random_phase(35, 5);

    drain();
    $display("Sent %0d line, clear and idle items (%0d clears) over six grid sizes.",
             items_sent, clears_sent);
    $display("Checked %0d scan results with random stalls on both channels.", results_seen);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
